/* hdl/ffaa_pkg.sv */
`default_nettype none

package ffaa_pkg;

	localparam int PAGE_SHIFT = 12;
	localparam int ADDR_W = 52;
	localparam int PAGES_W = 24;
	localparam int LEN_W = PAGES_W + PAGE_SHIFT;
	// Extent ends may pass the 52-bit space, so ends carry one more bit.
	localparam int END_W = ADDR_W + 1;
	localparam int ENTRY_W = ADDR_W + PAGES_W;
	localparam int TABLE_ENTRIES_DEF = 256;

	localparam logic [END_W-1:0] ADDR_LIMIT = {1'b1, {ADDR_W{1'b0}}};

	typedef enum logic {
		CMD_ALLOCATE = 1'b0,
		CMD_RESERVE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_NO_SPACE = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN
	} state_t;

endpackage

`default_nettype wire

/* hdl/first_fit_address_allocator_unit.sv */
`default_nettype none

// Channel    Handshake           Payload                      Direction
// command    start / busy        cmd, base_address, pages     in
// result     done (one cycle)    start_address, status        out
//
// A command beat is taken at a rising edge with start high and busy low, and gives one
// result beat, shown for one cycle with done high. Reserve and full-table commands answer
// in the cycle after the beat. Allocate runs passes over the U recorded extents: a limit
// check, one memory read per entry, a last compare and, if no collision, the write-back.
// A collision starts a new pass from the first entry. Reset clears control state and
// fill count, not the table. The receiver cannot stall: results are never held.

module first_fit_address_allocator_unit #(
	parameter int TABLE_ENTRIES = ffaa_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic                         cmd,
	input  wire logic [ffaa_pkg::ADDR_W-1:0]  base_address,
	input  wire logic [ffaa_pkg::PAGES_W-1:0] pages,
	output logic                              done,
	output logic [ffaa_pkg::ADDR_W-1:0]       start_address,
	output logic [1:0]                        status
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam int ADDR_W = ffaa_pkg::ADDR_W;
	localparam int PAGES_W = ffaa_pkg::PAGES_W;
	localparam int LEN_W = ffaa_pkg::LEN_W;
	localparam int END_W = ffaa_pkg::END_W;
	localparam int ENTRY_W = ffaa_pkg::ENTRY_W;

	// Control state.
	ffaa_pkg::state_t state_q, state_next;
	logic [CNT_W-1:0] used_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic             pend_s1;
	logic             done_q;

	// Payload registers of the command being worked on.
	logic [PAGES_W-1:0] pages_q;
	logic [END_W-1:0]   cand_q;
	logic [END_W-1:0]   cand_end_q;
	logic [ADDR_W-1:0]  start_address_q;
	ffaa_pkg::status_t  status_q;

	// The extent table: start address in the upper bits, page count below.
	logic [ENTRY_W-1:0] mem [TABLE_ENTRIES];
	logic [ENTRY_W-1:0] rd_data_s1;

	logic               accept;
	logic               table_full;
	logic               is_reserve;
	logic               issue_rd;
	logic               hit;
	logic               finish;
	logic               limit_fail;
	logic               mem_we;
	logic [ENTRY_W-1:0] mem_wdata;
	logic [LEN_W-1:0]   len;
	logic [END_W-1:0]   cand_sum;
	logic [ADDR_W-1:0]  ext_lo;
	logic [PAGES_W-1:0] ext_pages;
	logic [END_W-1:0]   ext_hi;
	logic               overlap;

	assign accept = start && !busy;
	assign table_full = (used_q == CNT_W'(TABLE_ENTRIES));
	assign is_reserve = (cmd == ffaa_pkg::CMD_RESERVE);

	// Candidate range length and end; the limit check works on the low
	// 52 bits since a candidate at or past the limit fails anyway.
	assign len = {pages_q, {ffaa_pkg::PAGE_SHIFT{1'b0}}};
	assign cand_sum = {1'b0, cand_q[ADDR_W-1:0]} + END_W'(len);
	assign limit_fail = cand_q[ADDR_W] || (cand_sum > ffaa_pkg::ADDR_LIMIT);

	// Half-open interval test against the entry read in the previous cycle.
	// An empty candidate or an empty extent overlaps nothing.
	assign ext_lo = rd_data_s1[ENTRY_W-1:PAGES_W];
	assign ext_pages = rd_data_s1[PAGES_W-1:0];
	assign ext_hi = {1'b0, ext_lo} + END_W'({ext_pages, {ffaa_pkg::PAGE_SHIFT{1'b0}}});
	assign overlap = (pages_q != '0) && (ext_pages != '0)
		&& ({1'b0, ext_lo} < cand_end_q) && (cand_q < ext_hi);

	// Next state.
	always_comb begin
		state_next = state_q;
		case (state_q)
			ffaa_pkg::S_IDLE: begin
				if (accept && !table_full && !is_reserve) begin
					state_next = ffaa_pkg::S_CHECK;
				end
			end
			ffaa_pkg::S_CHECK: begin
				state_next = limit_fail ? ffaa_pkg::S_IDLE : ffaa_pkg::S_SCAN;
			end
			ffaa_pkg::S_SCAN: begin
				if (hit) begin
					state_next = ffaa_pkg::S_CHECK;
				end else if (finish) begin
					state_next = ffaa_pkg::S_IDLE;
				end
			end
			default: begin
				state_next = ffaa_pkg::S_IDLE;
			end
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		busy = 1'b1;
		issue_rd = 1'b0;
		hit = 1'b0;
		finish = 1'b0;
		case (state_q)
			ffaa_pkg::S_IDLE: begin
				busy = 1'b0;
			end
			ffaa_pkg::S_CHECK: begin
				busy = 1'b1;
			end
			ffaa_pkg::S_SCAN: begin
				issue_rd = (rd_idx_q < used_q);
				hit = pend_s1 && overlap;
				finish = !pend_s1 && (rd_idx_q == used_q);
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	// One write port: a reserve at acceptance, or the found range at the end of a scan.
	assign mem_we = (accept && !table_full && is_reserve) || finish;
	assign mem_wdata = finish ? {cand_q[ADDR_W-1:0], pages_q} : {base_address, pages};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[used_q[IDX_W-1:0]] <= mem_wdata;
		end
		if (issue_rd) begin
			rd_data_s1 <= mem[rd_idx_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffaa_pkg::S_IDLE;
			used_q <= '0;
			rd_idx_q <= '0;
			pend_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_next;
			pend_s1 <= issue_rd;
			if (mem_we) begin
				used_q <= used_q + CNT_W'(1);
			end
			if (state_q == ffaa_pkg::S_CHECK) begin
				rd_idx_q <= '0;
			end else if (issue_rd) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
			done_q <= (accept && (table_full || is_reserve))
				|| (state_q == ffaa_pkg::S_CHECK && limit_fail) || finish;
		end
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			pages_q <= pages;
			cand_q <= {1'b0, base_address};
		end else if (hit) begin
			// Jump past the colliding extent and rescan from the first entry.
			cand_q <= ext_hi;
		end
		if (state_q == ffaa_pkg::S_CHECK) begin
			cand_end_q <= cand_sum;
		end
		if (accept && table_full) begin
			start_address_q <= '0;
			status_q <= ffaa_pkg::ST_FULL;
		end else if (accept && is_reserve) begin
			start_address_q <= base_address;
			status_q <= ffaa_pkg::ST_OK;
		end else if (state_q == ffaa_pkg::S_CHECK && limit_fail) begin
			start_address_q <= '0;
			status_q <= ffaa_pkg::ST_NO_SPACE;
		end else if (finish) begin
			start_address_q <= cand_q[ADDR_W-1:0];
			status_q <= ffaa_pkg::ST_OK;
		end
	end

	assign done = done_q;
	assign start_address = start_address_q;
	assign status = status_q;

	// The fill count never passes the table size.
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(TABLE_ENTRIES))
		else $error("fill count beyond table size");

	// Only recorded entries are ever read.
	a_read_recorded: assert property (@(posedge clk) disable iff (!arst_n)
		issue_rd |-> rd_idx_q < used_q)
		else $error("read of an unrecorded entry");

	// A command on a full table answers in the next cycle with the full status.
	a_full_answer: assert property (@(posedge clk) disable iff (!arst_n)
		accept && table_full |=> done && status == ffaa_pkg::ST_FULL && start_address == '0)
		else $error("full table not reported");

	// Every collision moves the candidate strictly upward.
	a_cand_grows: assert property (@(posedge clk) disable iff (!arst_n)
		hit |=> cand_q > $past(cand_q))
		else $error("candidate did not advance");

	// A failed result carries a zero address.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ffaa_pkg::ST_OK |-> start_address == '0)
		else $error("failed result with nonzero address");

endmodule

`default_nettype wire
